@@ design/hcbd_pkg.sv @@
// shared types, character codes and size-line helpers for the chunked body decoder
package hcbd_pkg;

  localparam int SIZE_BITS  = 32;  // width of a chunk size, 8 to 64
  localparam int COUNT_BITS = 32;  // width of the discard count
  localparam int OUT_BITS   = 48;  // result tdata, padded to whole bytes

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam logic [1:0] TRAIL_BYTES = 2'd2;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_DATA,
    PH_TRAIL,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    ST_ZERO_CHUNK,
    ST_UNTERMINATED,
    ST_BAD_SIZE,
    ST_TRUNCATED
  } status_t;

  typedef enum logic [1:0] {
    PP_LEADING,
    PP_ZERO,
    PP_PREFIX,
    PP_DIGITS
  } prefix_t;

  // everything a size-line character can touch
  typedef struct packed {
    phase_t                phase;
    logic [SIZE_BITS-1:0]  acc;
    logic                  digit_seen;
    prefix_t               prefix;
    status_t               stop_status;
  } line_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LC_A && c <= CH_LC_F) ||
           (c >= CH_UC_A && c <= CH_UC_F);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      v = c - CH_LC_A + 8'd10;
    end else begin
      v = c - CH_UC_A + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  // shift in one hex digit, stopping on overflow
  function automatic line_state_t accumulate(input line_state_t s, input logic [3:0] d);
    line_state_t r;
    r = s;
    if (|s.acc[SIZE_BITS-1 -: 4]) begin
      r.phase       = PH_STOP;
      r.stop_status = ST_BAD_SIZE;
    end else begin
      r.acc        = {s.acc[SIZE_BITS-5:0], d};
      r.digit_seen = 1'b1;
      r.prefix     = PP_DIGITS;
    end
    return r;
  endfunction

  // one ordinary character of a size line
  function automatic line_state_t feed_line_char(input line_state_t s, input logic [7:0] c);
    line_state_t r;
    r = s;
    if (s.phase == PH_SIZE) begin
      case (s.prefix)
        PP_LEADING: begin
          if (is_blank(c)) begin
            r = s;
          end else if (c == CH_ZERO) begin
            r.digit_seen = 1'b1;
            r.acc        = '0;
            r.prefix     = PP_ZERO;
          end else if (is_hex(c)) begin
            r.acc        = {{(SIZE_BITS-4){1'b0}}, hex_val(c)};
            r.digit_seen = 1'b1;
            r.prefix     = PP_DIGITS;
          end else begin
            r.phase = PH_EXT;
          end
        end
        PP_ZERO: begin
          if (c == CH_LC_X || c == CH_UC_X) begin
            r.prefix = PP_PREFIX;
          end else if (is_hex(c)) begin
            r = accumulate(s, hex_val(c));
          end else begin
            r.phase = PH_EXT;
          end
        end
        default: begin
          if (is_hex(c)) begin
            r = accumulate(s, hex_val(c));
          end else begin
            r.phase = PH_EXT;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ design/http_chunked_body_decoder_core.sv @@
// chunked transfer body decoder: body bytes in, payload bytes and final status out
//
//  channel  | dir | tdata (low bit up)                               | tuser       | tlast
//  ---------+-----+--------------------------------------------------+-------------+------------
//  s_axis   | in  | body_byte[7:0]                                   | -           | end_of_body
//  m_axis   | out | payload_byte[7:0], final_status[9:8],            | has_payload | final_marker
//           |     | discard_count[41:10], zero pad[47:42]            |             |
//
// one body byte per cycle unless m_axis stalls: each beat is decoded in the cycle it
// is taken and its result, if any, lands in a single output register
// s_axis_tready is high whenever that register is empty or being drained, so a new
// beat is taken while the previous result is handed over
// a stall on m_axis holds the result and backpressures s_axis the same cycle
// rst is synchronous; after reset and after every final beat the decoder waits for
// a new size line
module http_chunked_body_decoder_core
  import hcbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // body_byte
  input  logic                s_axis_tlast,   // end_of_body
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_BITS-1:0] m_axis_tdata,   // payload_byte, final_status, discard_count
  output logic                m_axis_tuser,   // has_payload
  output logic                m_axis_tlast    // final_marker
);

  // decoder state
  line_state_t            line_st, line_st_next;
  logic                   cr_seen, cr_seen_next;
  logic [SIZE_BITS-1:0]   bytes_remaining, bytes_remaining_next;
  logic [COUNT_BITS-1:0]  bytes_emitted, bytes_emitted_next;
  logic [1:0]             trail_cnt, trail_cnt_next;

  // size-line character paths: held CR only, held CR then this byte, this byte only
  line_state_t            line_cr, line_cr_b, line_b;

  logic                   in_accept;
  logic                   emit;
  logic                   res_valid;
  status_t                res_status;
  logic [COUNT_BITS-1:0]  res_discard;
  logic [7:0]             res_payload;

  // output register
  logic                   out_valid;
  logic [7:0]             out_payload;
  logic                   out_has_payload;
  logic                   out_final;
  status_t                out_status;
  logic [COUNT_BITS-1:0]  out_discard;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign line_cr   = feed_line_char(line_st, CH_CR);
  assign line_cr_b = feed_line_char(line_cr, s_axis_tdata);
  assign line_b    = feed_line_char(line_st, s_axis_tdata);

  // next state for the current beat
  always_comb begin
    line_st_next         = line_st;
    cr_seen_next         = cr_seen;
    bytes_remaining_next = bytes_remaining;
    bytes_emitted_next   = bytes_emitted;
    trail_cnt_next       = trail_cnt;
    case (line_st.phase)
      PH_SIZE, PH_EXT: begin
        if (cr_seen && s_axis_tdata == CH_LF) begin
          // end of size line
          cr_seen_next        = 1'b0;
          line_st_next.prefix = PP_LEADING;
          if (!line_st.digit_seen) begin
            line_st_next.phase       = PH_STOP;
            line_st_next.stop_status = ST_BAD_SIZE;
          end else if (line_st.acc == '0) begin
            line_st_next.phase       = PH_STOP;
            line_st_next.stop_status = ST_ZERO_CHUNK;
          end else begin
            bytes_remaining_next    = line_st.acc;
            bytes_emitted_next      = '0;
            line_st_next.acc        = '0;
            line_st_next.digit_seen = 1'b0;
            line_st_next.phase      = PH_DATA;
          end
        end else if (cr_seen) begin
          // lone cr counts as a line character
          if (s_axis_tdata == CH_CR) begin
            line_st_next = line_cr;
            cr_seen_next = 1'b1;
          end else begin
            line_st_next = line_cr_b;
            cr_seen_next = 1'b0;
          end
        end else if (s_axis_tdata == CH_CR) begin
          cr_seen_next = 1'b1;
        end else begin
          line_st_next = line_b;
        end
      end
      PH_DATA: begin
        if (bytes_remaining != '0) begin
          bytes_remaining_next = bytes_remaining - 1'b1;
        end
        if (!(&bytes_emitted)) begin
          bytes_emitted_next = bytes_emitted + 1'b1;
        end
        if (bytes_remaining_next == '0) begin
          line_st_next.phase = PH_TRAIL;
          trail_cnt_next     = TRAIL_BYTES;
        end
      end
      PH_TRAIL: begin
        if (trail_cnt != 2'd0) begin
          trail_cnt_next = trail_cnt - 1'b1;
        end
        if (trail_cnt_next == 2'd0) begin
          line_st_next.phase      = PH_SIZE;
          line_st_next.prefix     = PP_LEADING;
          line_st_next.digit_seen = 1'b0;
          line_st_next.acc        = '0;
          cr_seen_next            = 1'b0;
        end
      end
      default: begin
        // stopped: bytes ignored until the final beat
        line_st_next = line_st;
      end
    endcase
  end

  // result for the current beat, status taken after the beat's update
  always_comb begin
    emit        = line_st.phase == PH_DATA;
    res_valid   = emit || s_axis_tlast;
    res_payload = emit ? s_axis_tdata : 8'd0;
    res_status  = ST_ZERO_CHUNK;
    res_discard = '0;
    if (s_axis_tlast) begin
      case (line_st_next.phase)
        PH_STOP: res_status = line_st_next.stop_status;
        PH_DATA: begin
          res_status  = ST_TRUNCATED;
          res_discard = bytes_emitted_next;
        end
        default: res_status = ST_UNTERMINATED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_axis_tlast)) begin
      line_st.phase       <= PH_SIZE;
      line_st.acc         <= '0;
      line_st.digit_seen  <= 1'b0;
      line_st.prefix      <= PP_LEADING;
      line_st.stop_status <= ST_ZERO_CHUNK;
      cr_seen             <= 1'b0;
      bytes_remaining     <= '0;
      bytes_emitted       <= '0;
      trail_cnt           <= 2'd0;
    end else if (in_accept) begin
      line_st         <= line_st_next;
      cr_seen         <= cr_seen_next;
      bytes_remaining <= bytes_remaining_next;
      bytes_emitted   <= bytes_emitted_next;
      trail_cnt       <= trail_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= in_accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      out_payload     <= res_payload;
      out_has_payload <= emit;
      out_final       <= s_axis_tlast;
      out_status      <= res_status;
      out_discard     <= res_discard;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_BITS-COUNT_BITS-10){1'b0}}, out_discard, out_status, out_payload};
  assign m_axis_tuser  = out_has_payload;
  assign m_axis_tlast  = out_final;

endmodule
